// ===== design/prefix_table_match_macros.svh =====
// Assertion macros shared by the prefix table match checker.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef PREFIX_TABLE_MATCH_MACROS_SVH
`define PREFIX_TABLE_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prefix_table_match: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prefix_table_match: next-cycle check failed");

`endif

// ===== design/ptm_pkg.sv =====
// Package for the prefix table match block: sizes, codes and state type.
// Depends on nothing; imported by prefix_table_match.
package ptm_pkg;

    localparam int ENTRIES  = 16;
    localparam int NAME_LEN = 16;
    localparam int CHAR_W   = 8;

    localparam int DEPTH = ENTRIES * NAME_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int PW    = $clog2(NAME_LEN + 1);
    localparam int LW    = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STAT_STORED = 1'b0;
    localparam logic STAT_FULL   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // Character memory address of entry e, position p.
    function automatic logic [AW-1:0] store_addr(logic [EW-1:0] e, logic [LW-1:0] p);
        return AW'(e) * AW'(NAME_LEN) + AW'(p);
    endfunction

endpackage

// ===== design/ptm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/prefix_table_match.sv =====
// Prefix table match: items are accepted only in the idle state. A non-final add item, or a
// non-final query item with no character to compare, leaves the block idle; a final add
// item passes through the finish state, which loads its result for output. Any other query
// item walks the stored entries through the single memory read port, one read per entry,
// then the finish state when final; a held result stalls a final item there.
// Reset is synchronous and active low; a clearing pass of all DEPTH addresses follows.
module prefix_table_match
    import ptm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [CHAR_W-1:0] i_ch,
    input  logic              i_has_char,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_status,
    output logic              o_matched
);

    // Control state.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_pos;
    logic [ENTRIES-1:0] r_still;
    logic [PW-1:0]     r_len [ENTRIES];
    logic [CW-1:0]     r_rd_idx;
    logic              r_pv;
    logic              r_ovalid;

    // Item and result holding registers.
    logic [CHAR_W-1:0] r_ch;
    logic              r_cmp;
    logic              r_last;
    logic [PW-1:0]     r_cpos;
    logic [PW-1:0]     r_hpos;
    logic [EW-1:0]     r_pidx;
    logic              r_hit;
    logic              r_res_status;
    logic              r_res_matched;
    logic              r_ostatus;
    logic              r_omatched;

    // Memory port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              accept;
    logic              has_room;
    logic              cmp_now;
    logic [PW-1:0]     pos_new;
    logic              issue;
    logic              walk_done;
    logic              load_out;
    logic [PW-1:0]     cur_len;
    logic              mismatch;
    logic              keep;
    logic              hit_e;

    // The character memory holds every entry's characters, entry-major. It is written by
    // the clearing pass and by add characters, and read by the query walk. Items are only
    // accepted when idle, so a walk never overlaps a write and no forwarding is needed.
    ptm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign has_room = r_count < CW'(ENTRIES);
    // Characters beyond NAME_LEN are neither stored nor compared.
    assign cmp_now  = i_has_char && (r_pos < PW'(NAME_LEN));
    assign pos_new  = cmp_now ? r_pos + PW'(1) : r_pos;

    // The walk issues one memory read per stored entry; the data returns in the next cycle,
    // when r_pv marks entry r_pidx as ready to be judged.
    assign issue     = (r_state == ST_WALK) && (r_rd_idx < r_count);
    assign walk_done = (r_state == ST_WALK) && !issue && !r_pv;

    // Judge one entry: a stored character within the prefix that differs from the query
    // character rules the entry out. A surviving entry hits at the final item when its
    // whole prefix has been covered by the query.
    assign cur_len  = r_len[r_pidx];
    assign mismatch = r_cmp && (r_cpos < cur_len) && (ram_rdata != r_ch);
    assign keep     = r_still[r_pidx] && !mismatch;
    assign hit_e    = keep && (cur_len <= r_hpos);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_QUERY && (cmp_now || i_last)) begin
                        n_state = ST_WALK;
                    end else if (i_last) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = r_last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = '0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_waddr  = store_addr(r_count[EW-1:0], r_pos[LW-1:0]);
                ram_wdata  = i_ch;
                ram_we     = accept && (i_op == OP_ADD) && cmp_now && has_room;
            end
            ST_WALK: begin
            end
            ST_FINISH: begin
                load_out = !r_ovalid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign ram_raddr = store_addr(r_rd_idx[EW-1:0], r_cpos[LW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_pos      <= '0;
            r_still    <= '1;
            r_len      <= '{default: '0};
            r_rd_idx   <= '0;
            r_pv       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            if (accept) begin
                r_ch     <= i_ch;
                r_cmp    <= cmp_now;
                r_last   <= i_last;
                r_cpos   <= r_pos;
                r_hpos   <= pos_new;
                r_rd_idx <= '0;
                r_hit    <= 1'b0;
                r_pos    <= i_last ? '0 : pos_new;
                if (i_op == OP_ADD && i_last) begin
                    // An add ends: commit its length if there was room.
                    r_res_matched <= 1'b0;
                    r_still       <= '1;
                    if (has_room) begin
                        r_len[r_count[EW-1:0]] <= pos_new;
                        r_count                <= r_count + CW'(1);
                        r_res_status           <= STAT_STORED;
                    end else begin
                        r_res_status <= STAT_FULL;
                    end
                end
            end

            r_pv <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
                r_pidx   <= r_rd_idx[EW-1:0];
            end

            if (r_pv) begin
                r_still[r_pidx] <= keep;
                if (hit_e) begin
                    r_hit <= 1'b1;
                end
            end

            if (walk_done && r_last) begin
                // A query ends: every entry is back in the running for the next string.
                r_still       <= '1;
                r_res_status  <= STAT_STORED;
                r_res_matched <= r_hit;
            end

            // A new result may replace one that is being taken in the same cycle.
            if (load_out) begin
                r_ovalid   <= 1'b1;
                r_ostatus  <= r_res_status;
                r_omatched <= r_res_matched;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_matched   = r_omatched;

endmodule

// ===== design/ptm_checker.sv =====
// Port-level checker for prefix_table_match, attached by the bind at the end of this file.
// Depends on prefix_table_match_macros.svh.
`include "prefix_table_match_macros.svh"

module ptm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_op,
    input logic [7:0] i_ch,
    input logic       i_has_char,
    input logic       i_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_status,
    input logic       o_matched
);

    // A result held back by the consumer stays offered.
    `PTM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A held result keeps its fields.
    `PTM_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_status) && $stable(o_matched))

    // No result reports a full table together with a match.
    `PTM_ASSERT_IMPL(a_excl, o_out_valid, !(o_status && o_matched))

    // The final item of a string is followed by a busy cycle while its result is formed.
    `PTM_ASSERT_NEXT(a_last_busy, i_in_valid && o_in_ready && i_last, !o_in_ready)

endmodule

bind prefix_table_match ptm_checker u_ptm_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for prefix_table_match: prefix adds and queries over a
// valid/ready pair of channels, checked against a behavioural table kept alongside.
// Depends on ptm_pkg and the prefix_table_match RTL only.
`timescale 1ns / 1ps

module tb_top;
    import ptm_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int IDLE_PCT    = 19;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t char_q_t[$];

    // One answer of the block: add status and query match flag.
    typedef struct packed {
        logic status;
        logic matched;
    } verdict_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    logic  i_op;
    char_t i_ch;
    logic  i_has_char;
    logic  i_last;
    logic  o_out_valid;
    logic  i_out_ready;
    logic  o_status;
    logic  o_matched;

    prefix_table_match uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_matched   (o_matched)
    );

    // Shadow copy of the prefix table. Only the slot at names_held is ever
    // written by add characters, so stored entries never change once counted.
    char_t              held_chars [ENTRIES][NAME_LEN];
    int                 held_len [ENTRIES];
    int                 names_held;
    int                 str_pos;
    logic [ENTRIES-1:0] alive;

    verdict_t pending_verdicts[$];
    verdict_t oldest_verdict;
    int       mismatch_count;
    int       items_sent;
    bit       steady;       // when set, neither side idles
    int       hold_cycles;  // requested receiver hold-off, consumed by the receiver

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Updates the shadow table with one accepted item and, on the final item of
    // a string, queues the answer that the block must give for that string.
    function automatic void track_table_item(logic op, char_t ch, logic has_char, logic last);
        verdict_t v;
        if (has_char && str_pos < NAME_LEN) begin
            if (op == OP_ADD) begin
                if (names_held < ENTRIES)
                    held_chars[names_held][str_pos] = ch;
            end else begin
                // Rule out every entry whose character at this position differs;
                // entries shorter than the position are left alone.
                for (int e = 0; e < names_held; e++)
                    if (str_pos < held_len[e] && held_chars[e][str_pos] != ch)
                        alive[e] = 1'b0;
            end
            str_pos++;
        end
        if (last) begin
            v.status  = STAT_STORED;
            v.matched = 1'b0;
            if (op == OP_ADD) begin
                if (names_held < ENTRIES) begin
                    held_len[names_held] = str_pos;
                    names_held++;
                end else begin
                    v.status = STAT_FULL;
                end
            end else begin
                // A prefix longer than the query cannot match it.
                for (int e = 0; e < names_held; e++)
                    if (alive[e] && held_len[e] <= str_pos)
                        v.matched = 1'b1;
            end
            pending_verdicts.push_back(v);
            str_pos = 0;
            alive   = '1;
        end
    endfunction

    // Mostly a four-letter alphabet so that queries share prefixes with the
    // stored names; the rest are arbitrary bytes.
    function automatic char_t rand_char();
        if ($urandom_range(9) < 7)
            return 8'h61 + char_t'($urandom_range(3));
        return char_t'($urandom);
    endfunction

    function automatic char_q_t random_name(int n);
        char_q_t q;
        for (int k = 0; k < n; k++)
            q.push_back(rand_char());
        return q;
    endfunction

    // Offers one item and returns once it has been accepted. Valid is left high
    // so that a back-to-back item keeps it asserted without a dip.
    task automatic send_item(input logic op, input char_t ch, input logic has_char,
                             input logic last);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_ch       <= ch;
        i_has_char <= has_char;
        i_last     <= last;
        do @(posedge i_clk); while (!o_in_ready);
        track_table_item(op, ch, has_char, last);
        items_sent++;
    endtask

    // Sends a whole string. With noise, empty items are slipped in between the
    // characters and now and then a character goes with the other op. The end
    // of the string is either on its last character or on a separate empty item.
    task automatic send_string(input logic op, input char_q_t chars, input bit noisy);
        int  n;
        bit  split_end;
        n = chars.size();
        split_end = (n == 0) || ($urandom_range(3) == 0);
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(19) == 0)
                send_item(op, char_t'($urandom), 1'b0, 1'b0);
            send_item((noisy && $urandom_range(29) == 0) ? ~op : op, chars[k], 1'b1,
                      (k == n - 1) && !split_end);
        end
        if (split_end)
            send_item(op, char_t'($urandom), 1'b0, 1'b1);
    endtask

    // Random strings until item_goal items have gone in. Adds are made only
    // while fewer than add_cap names are held; most queries are built from a
    // stored name, taken exactly, extended, cut short or with one bit changed.
    task automatic run_random_strings(input int item_goal, input int add_cap);
        char_q_t name;
        int      pick;
        int      e;
        int      cut;
        int      k;
        while (items_sent < item_goal) begin
            if (names_held < add_cap && $urandom_range(5) == 0) begin
                if ($urandom_range(7) == 0)
                    name = random_name($urandom_range(1, NAME_LEN + 4));
                else
                    name = random_name($urandom_range(2, 5));
                send_string(OP_ADD, name, 1'b1);
            end else begin
                pick = $urandom_range(9);
                if (names_held == 0 || pick < 2) begin
                    name = random_name($urandom_range(NAME_LEN + 4));
                end else begin
                    e = $urandom_range(names_held - 1);
                    name = {};
                    for (int j = 0; j < held_len[e]; j++)
                        name.push_back(held_chars[e][j]);
                    if (pick == 5 || pick == 6) begin
                        name = {name, random_name($urandom_range(1, 6))};
                    end else if (pick == 7 && name.size() > 0) begin
                        cut = $urandom_range(name.size() - 1);
                        while (name.size() > cut)
                            void'(name.pop_back());
                    end else if (pick >= 8 && name.size() > 0) begin
                        k = $urandom_range(name.size() - 1);
                        name[k] = name[k] ^ (char_t'(1) << $urandom_range(CHAR_W - 1));
                    end
                end
                send_string(OP_QUERY, name, 1'b1);
            end
        end
    endtask

    // Queries against an empty table never match, the empty query included.
    task automatic test_empty_table();
        send_item(OP_QUERY, 8'h00, 1'b0, 1'b1);
        send_string(OP_QUERY, random_name(3), 1'b0);
    endtask

    // Hand-made adds and queries for the corner cases of the table.
    task automatic test_directed_strings();
        // "ab", then a query that is shorter than it and one that runs past it
        // with empty items in between.
        send_string(OP_ADD, '{8'h61, 8'h62}, 1'b0);
        send_item(OP_QUERY, 8'h61, 1'b1, 1'b1);
        send_item(OP_QUERY, 8'h61, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'hA5, 1'b0, 1'b0);
        send_item(OP_QUERY, 8'h62, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'h7A, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'h5A, 1'b0, 1'b1);
        // Character zero is an ordinary value, as is the top code.
        send_string(OP_ADD, '{8'h00, 8'hFF}, 1'b0);
        send_string(OP_QUERY, '{8'h00, 8'hFF}, 1'b0);
        // A name one longer than the table allows keeps only its first part.
        send_string(OP_ADD, random_name(NAME_LEN + 1), 1'b0);
        // Mixed ops: the op of the final item decides the kind of answer.
        send_item(OP_QUERY, 8'h64, 1'b1, 1'b0);
        send_item(OP_ADD, 8'h65, 1'b1, 1'b1);
        send_item(OP_ADD, 8'h78, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'h79, 1'b1, 1'b1);
    endtask

    // The receiver refuses results for a long while as items keep coming, so
    // the block has to hold its answer and stop taking input.
    task automatic test_backpressure();
        hold_cycles = 300;
        run_random_strings(items_sent + 60, ENTRIES - 1);
    endtask

    task automatic test_random_strings();
        run_random_strings(700, ENTRIES - 1);
    endtask

    // A long burst with neither side idling.
    task automatic test_steady_stream();
        steady = 1'b1;
        run_random_strings(1000, ENTRIES - 1);
        steady = 1'b0;
    endtask

    // Fill the table up to its last slot, then store the empty name there:
    // from then on every query matches.
    task automatic test_empty_prefix();
        run_random_strings(1500, ENTRIES - 1);
        while (names_held < ENTRIES - 1)
            send_string(OP_ADD, random_name($urandom_range(2, 5)), 1'b1);
        send_item(OP_ADD, char_t'($urandom), 1'b0, 1'b1);
        send_string(OP_QUERY, random_name(4), 1'b0);
    endtask

    // With the table full every add answers full and stores nothing.
    task automatic test_full_table();
        run_random_strings(1950, ENTRIES + 1);
    endtask

    // Results are taken on every edge where valid and ready meet and compared
    // with the oldest answer still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0b matched %0b",
                         $time, o_status, o_matched);
                mismatch_count++;
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (o_status !== oldest_verdict.status) begin
                    $display("%0t: status mismatch, expected %0b, got %0b",
                             $time, oldest_verdict.status, o_status);
                    mismatch_count++;
                end
                if (o_matched !== oldest_verdict.matched) begin
                    $display("%0t: matched mismatch, expected %0b, got %0b",
                             $time, oldest_verdict.matched, o_matched);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: ready at random, or held low for a requested number of cycles.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a run that hangs counts as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_ADD;
        i_ch           = '0;
        i_has_char     = 1'b0;
        i_last         = 1'b0;
        names_held     = 0;
        str_pos        = 0;
        alive          = '1;
        mismatch_count = 0;
        items_sent     = 0;
        steady         = 1'b0;
        hold_cycles    = 0;
        for (int e = 0; e < ENTRIES; e++) begin
            held_len[e] = 0;
            for (int p = 0; p < NAME_LEN; p++)
                held_chars[e][p] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block runs its clearing pass first; the handshake covers that.
        test_empty_table();
        test_directed_strings();
        test_backpressure();
        test_random_strings();
        test_steady_stream();
        test_empty_prefix();
        test_full_table();
        i_in_valid <= 1'b0;

        // Drain the owed answers, then leave room for a stray late result.
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== prefix_table_match.f =====
+incdir+design
design/ptm_pkg.sv
design/ptm_ram.sv
design/prefix_table_match.sv
design/ptm_checker.sv
tb/tb_top.sv
